/* sv/clt_pkg.sv */
// ----------------------------------------------------------------------------
// Command line tokenizer package
// Shared sizes, character codes, types and helpers of the tokenizer.
// ----------------------------------------------------------------------------
package clt_pkg;

  // Field capacities in characters (1 to 8 each)
  localparam int CMD_CHARS = 4;
  localparam int ARG_CHARS = 8;
  localparam int VAL_CHARS = 8;
  localparam int MAX_CHARS = 8;

  // Widths of the result fields
  localparam int CMD_TEXT_W = 32;
  localparam int ARG_TEXT_W = 64;
  localparam int VAL_TEXT_W = 64;
  localparam int CMD_TEXT_BYTES = CMD_TEXT_W / 8;
  localparam int ARG_TEXT_BYTES = ARG_TEXT_W / 8;
  localparam int VAL_TEXT_BYTES = VAL_TEXT_W / 8;
  localparam int CMD_LEN_OUT_W = 3;
  localparam int ARG_LEN_OUT_W = 4;
  localparam int VAL_LEN_OUT_W = 4;

  // Internal length and pointer widths
  localparam int PTR_W     = $clog2(MAX_CHARS + 1);
  localparam int CMD_LEN_W = $clog2(CMD_CHARS + 1);
  localparam int ARG_LEN_W = $clog2(ARG_CHARS + 1);
  localparam int VAL_LEN_W = $clog2(VAL_CHARS + 1);

  typedef logic [7:0]           byte_t;
  typedef logic [PTR_W-1:0]     ptr_t;
  typedef logic [CMD_LEN_W-1:0] cmd_len_t;
  typedef logic [ARG_LEN_W-1:0] arg_len_t;
  typedef logic [VAL_LEN_W-1:0] val_len_t;

  // Character codes
  localparam byte_t CH_NUL    = 8'h00;
  localparam byte_t CH_BS     = 8'h08;
  localparam byte_t CH_TAB    = 8'h09;
  localparam byte_t CH_LF     = 8'h0A;
  localparam byte_t CH_VT     = 8'h0B;
  localparam byte_t CH_FF     = 8'h0C;
  localparam byte_t CH_CR     = 8'h0D;
  localparam byte_t CH_CTRL_U = 8'h15;
  localparam byte_t CH_SPACE  = 8'h20;
  localparam byte_t CH_HASH   = 8'h23;

  // Part of the line being filled
  typedef enum logic [5:0] {
    PART_CMD  = 6'b000001,
    PART_ARG  = 6'b000010,
    PART_VAL  = 6'b000100,
    PART_GAP1 = 6'b001000,
    PART_GAP2 = 6'b010000,
    PART_NOTE = 6'b100000
  } part_t;

  // One result item
  typedef struct packed {
    logic                     echo_valid;
    byte_t                    echo_byte;
    logic                     line_done;
    logic [CMD_TEXT_W-1:0]    cmd_text;
    logic [CMD_LEN_OUT_W-1:0] cmd_len;
    logic [ARG_TEXT_W-1:0]    arg_text;
    logic [ARG_LEN_OUT_W-1:0] arg_len;
    logic [VAL_TEXT_W-1:0]    val_text;
    logic [VAL_LEN_OUT_W-1:0] val_len;
  } result_t;

  function automatic logic is_blank(input byte_t c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) ||
           (c == CH_FF) || (c == CH_CR);
  endfunction

endpackage

/* sv/clt_if.sv */
// ----------------------------------------------------------------------------
// Command line tokenizer channels
// Valid/ready channels for received bytes, result items and configuration.
// ----------------------------------------------------------------------------
interface clt_in_if;
  logic          valid;
  logic          ready;
  clt_pkg::byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface clt_out_if;
  logic                              valid;
  logic                              ready;
  logic                              echo_valid;
  clt_pkg::byte_t                    echo_byte;
  logic                              line_done;
  logic [clt_pkg::CMD_TEXT_W-1:0]    cmd_text;
  logic [clt_pkg::CMD_LEN_OUT_W-1:0] cmd_len;
  logic [clt_pkg::ARG_TEXT_W-1:0]    arg_text;
  logic [clt_pkg::ARG_LEN_OUT_W-1:0] arg_len;
  logic [clt_pkg::VAL_TEXT_W-1:0]    val_text;
  logic [clt_pkg::VAL_LEN_OUT_W-1:0] val_len;

  modport source (output valid, output echo_valid, output echo_byte, output line_done,
                  output cmd_text, output cmd_len, output arg_text, output arg_len,
                  output val_text, output val_len, input ready);
  modport sink   (input valid, input echo_valid, input echo_byte, input line_done,
                  input cmd_text, input cmd_len, input arg_text, input arg_len,
                  input val_text, input val_len, output ready);
endinterface

interface clt_cfg_if;
  logic valid;
  logic ready;
  logic echo_enable;

  modport source (output valid, output echo_enable, input ready);
  modport sink   (input valid, input echo_enable, output ready);
endinterface

/* sv/command_line_tokenizer_core.sv */
// ----------------------------------------------------------------------------
// Command line tokenizer core
// Splits received lines into command, argument and value text fields.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan  : one received byte per item (rx_byte); byte 0 is ignored.
//   out_chan : exactly one result item per input item: the echo byte and,
//              on a newline, the packed command, argument and value fields
//              with their lengths. All text and length fields read zero when
//              line_done is low.
//   cfg_chan : writes echo_enable; always ready. Write it only while idle.
// Timing:
//   An item enters the input register, then combinational logic folds it
//   into the line state and loads the result register, which drives
//   out_chan; a stall can hold the item in either register. One item per
//   cycle is sustained while out_chan.ready stays high; the rate is set by
//   the state update.
// Reset:
//   rst_n low empties both registers, sets the command part, a zero pointer,
//   zero lengths and cleared text stores, and clears echo_enable.
// Stall:
//   While the receiver holds out_chan.ready low the result register holds;
//   the input register still takes one more item, then in_chan.ready drops.
// ----------------------------------------------------------------------------
module command_line_tokenizer_core (
  input  logic       clk,
  input  logic       rst_n,
  clt_in_if.sink     in_chan,
  clt_out_if.source  out_chan,
  clt_cfg_if.sink    cfg_chan
);

  // Input register
  logic                s0_valid_r;
  clt_pkg::byte_t      s0_byte_r;
  logic                s0_adv;

  // Result register
  logic                out_valid_r;
  clt_pkg::result_t    res_r;
  clt_pkg::result_t    res_nxt;

  // Configuration
  logic                echo_enable_r;

  // Line state
  clt_pkg::part_t      part_r, part_nxt, part_eff;
  clt_pkg::ptr_t       wp_r, wp_nxt;
  clt_pkg::byte_t      cmd_chars_r [clt_pkg::CMD_CHARS];
  clt_pkg::byte_t      cmd_chars_nxt [clt_pkg::CMD_CHARS];
  clt_pkg::byte_t      arg_chars_r [clt_pkg::ARG_CHARS];
  clt_pkg::byte_t      arg_chars_nxt [clt_pkg::ARG_CHARS];
  clt_pkg::byte_t      val_chars_r [clt_pkg::VAL_CHARS];
  clt_pkg::byte_t      val_chars_nxt [clt_pkg::VAL_CHARS];
  clt_pkg::cmd_len_t   cmd_length_r, cmd_length_nxt;
  clt_pkg::arg_len_t   arg_length_r, arg_length_nxt;
  clt_pkg::val_len_t   val_length_r, val_length_nxt;

  // Packed views of the stored fields
  logic [clt_pkg::CMD_TEXT_W-1:0] cmd_pack;
  logic [clt_pkg::ARG_TEXT_W-1:0] arg_pack;
  logic [clt_pkg::VAL_TEXT_W-1:0] val_pack;
  logic [clt_pkg::PTR_W-1:0]      cmd_len_ext;
  logic [clt_pkg::CMD_LEN_OUT_W-1:0] cmd_len_sat;

  // --------------------------------------------------------------------------
  // Handshakes: the input register advances whenever the result register is
  // empty or being emptied this cycle.
  // --------------------------------------------------------------------------
  assign s0_adv        = s0_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s0_valid_r || s0_adv;
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s0_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s0_byte_r <= in_chan.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_enable_r <= 1'b0;
    end else if (cfg_chan.valid) begin
      echo_enable_r <= cfg_chan.echo_enable;
    end
  end

  // --------------------------------------------------------------------------
  // Pack each field: bytes below the length, zero elsewhere.
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < clt_pkg::CMD_TEXT_BYTES; i++) begin : g_cmd_pack
    if (i < clt_pkg::CMD_CHARS) begin : g_used
      assign cmd_pack[8*i +: 8] =
        (clt_pkg::ptr_t'(cmd_length_r) > clt_pkg::ptr_t'(i)) ? cmd_chars_r[i] : 8'h00;
    end else begin : g_pad
      assign cmd_pack[8*i +: 8] = 8'h00;
    end
  end

  for (genvar i = 0; i < clt_pkg::ARG_TEXT_BYTES; i++) begin : g_arg_pack
    if (i < clt_pkg::ARG_CHARS) begin : g_used
      assign arg_pack[8*i +: 8] =
        (clt_pkg::ptr_t'(arg_length_r) > clt_pkg::ptr_t'(i)) ? arg_chars_r[i] : 8'h00;
    end else begin : g_pad
      assign arg_pack[8*i +: 8] = 8'h00;
    end
  end

  for (genvar i = 0; i < clt_pkg::VAL_TEXT_BYTES; i++) begin : g_val_pack
    if (i < clt_pkg::VAL_CHARS) begin : g_used
      assign val_pack[8*i +: 8] =
        (clt_pkg::ptr_t'(val_length_r) > clt_pkg::ptr_t'(i)) ? val_chars_r[i] : 8'h00;
    end else begin : g_pad
      assign val_pack[8*i +: 8] = 8'h00;
    end
  end

  // Saturate a command length that outgrows its output field
  assign cmd_len_ext = clt_pkg::ptr_t'(cmd_length_r);
  assign cmd_len_sat = (cmd_len_ext > clt_pkg::ptr_t'({clt_pkg::CMD_LEN_OUT_W{1'b1}})) ?
                       {clt_pkg::CMD_LEN_OUT_W{1'b1}} :
                       cmd_len_ext[clt_pkg::CMD_LEN_OUT_W-1:0];

  // '#' takes over the part before the part decides what to do
  assign part_eff = (s0_byte_r == clt_pkg::CH_HASH) ? clt_pkg::PART_NOTE : part_r;

  // --------------------------------------------------------------------------
  // Fold the held byte into the line and build its result item.
  // --------------------------------------------------------------------------
  always_comb begin
    part_nxt       = part_r;
    wp_nxt         = wp_r;
    cmd_chars_nxt  = cmd_chars_r;
    arg_chars_nxt  = arg_chars_r;
    val_chars_nxt  = val_chars_r;
    cmd_length_nxt = cmd_length_r;
    arg_length_nxt = arg_length_r;
    val_length_nxt = val_length_r;
    res_nxt        = '0;

    if (s0_byte_r == clt_pkg::CH_NUL) begin
      // no character: leave everything, report zeros
    end else if (s0_byte_r == clt_pkg::CH_CTRL_U) begin
      // drop the line, always answer with a carriage return
      cmd_length_nxt     = '0;
      arg_length_nxt     = '0;
      val_length_nxt     = '0;
      wp_nxt             = '0;
      part_nxt           = clt_pkg::PART_CMD;
      res_nxt.echo_valid = 1'b1;
      res_nxt.echo_byte  = clt_pkg::CH_CR;
    end else begin
      if (echo_enable_r) begin
        res_nxt.echo_valid = 1'b1;
        res_nxt.echo_byte  = s0_byte_r;
      end

      if (s0_byte_r == clt_pkg::CH_BS) begin
        // back up the pointer only; lengths follow on the next store
        if (wp_r != '0) begin
          wp_nxt = wp_r - clt_pkg::ptr_t'(1);
        end
      end else if (s0_byte_r == clt_pkg::CH_LF) begin
        res_nxt.line_done = 1'b1;
        res_nxt.cmd_text  = cmd_pack;
        res_nxt.cmd_len   = cmd_len_sat;
        res_nxt.arg_text  = arg_pack;
        res_nxt.arg_len   = clt_pkg::ARG_LEN_OUT_W'(arg_length_r);
        res_nxt.val_text  = val_pack;
        res_nxt.val_len   = clt_pkg::VAL_LEN_OUT_W'(val_length_r);
        wp_nxt            = '0;
        part_nxt          = clt_pkg::PART_CMD;
        cmd_length_nxt    = '0;
        arg_length_nxt    = '0;
        val_length_nxt    = '0;
      end else begin
        part_nxt = part_eff;
        unique case (part_eff)
          clt_pkg::PART_CMD: begin
            if (clt_pkg::is_blank(s0_byte_r)) begin
              part_nxt = clt_pkg::PART_GAP1;
            end else if (wp_r < clt_pkg::ptr_t'(clt_pkg::CMD_CHARS)) begin
              for (int i = 0; i < clt_pkg::CMD_CHARS; i++) begin
                if (wp_r == clt_pkg::ptr_t'(i)) cmd_chars_nxt[i] = s0_byte_r;
              end
              wp_nxt         = wp_r + clt_pkg::ptr_t'(1);
              cmd_length_nxt = clt_pkg::cmd_len_t'(wp_r + clt_pkg::ptr_t'(1));
            end
          end
          clt_pkg::PART_GAP1: begin
            if (!clt_pkg::is_blank(s0_byte_r)) begin
              arg_chars_nxt[0] = s0_byte_r;
              arg_length_nxt   = clt_pkg::arg_len_t'(1);
              wp_nxt           = clt_pkg::ptr_t'(1);
              part_nxt         = clt_pkg::PART_ARG;
            end
          end
          clt_pkg::PART_ARG: begin
            if (clt_pkg::is_blank(s0_byte_r)) begin
              part_nxt = clt_pkg::PART_GAP2;
            end else if (wp_r < clt_pkg::ptr_t'(clt_pkg::ARG_CHARS)) begin
              for (int i = 0; i < clt_pkg::ARG_CHARS; i++) begin
                if (wp_r == clt_pkg::ptr_t'(i)) arg_chars_nxt[i] = s0_byte_r;
              end
              wp_nxt         = wp_r + clt_pkg::ptr_t'(1);
              arg_length_nxt = clt_pkg::arg_len_t'(wp_r + clt_pkg::ptr_t'(1));
            end
          end
          clt_pkg::PART_GAP2: begin
            if (!clt_pkg::is_blank(s0_byte_r)) begin
              val_chars_nxt[0] = s0_byte_r;
              val_length_nxt   = clt_pkg::val_len_t'(1);
              wp_nxt           = clt_pkg::ptr_t'(1);
              part_nxt         = clt_pkg::PART_VAL;
            end
          end
          clt_pkg::PART_VAL: begin
            // the value keeps blanks
            if (wp_r < clt_pkg::ptr_t'(clt_pkg::VAL_CHARS)) begin
              for (int i = 0; i < clt_pkg::VAL_CHARS; i++) begin
                if (wp_r == clt_pkg::ptr_t'(i)) val_chars_nxt[i] = s0_byte_r;
              end
              wp_nxt         = wp_r + clt_pkg::ptr_t'(1);
              val_length_nxt = clt_pkg::val_len_t'(wp_r + clt_pkg::ptr_t'(1));
            end
          end
          clt_pkg::PART_NOTE: begin
            // comment: ignore until the newline
          end
          default: begin
          end
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Commit the line state and the result item together.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_r       <= clt_pkg::PART_CMD;
      wp_r         <= '0;
      cmd_length_r <= '0;
      arg_length_r <= '0;
      val_length_r <= '0;
      for (int i = 0; i < clt_pkg::CMD_CHARS; i++) cmd_chars_r[i] <= '0;
      for (int i = 0; i < clt_pkg::ARG_CHARS; i++) arg_chars_r[i] <= '0;
      for (int i = 0; i < clt_pkg::VAL_CHARS; i++) val_chars_r[i] <= '0;
    end else if (s0_adv) begin
      part_r       <= part_nxt;
      wp_r         <= wp_nxt;
      cmd_length_r <= cmd_length_nxt;
      arg_length_r <= arg_length_nxt;
      val_length_r <= val_length_nxt;
      cmd_chars_r  <= cmd_chars_nxt;
      arg_chars_r  <= arg_chars_nxt;
      val_chars_r  <= val_chars_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s0_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_adv) begin
      res_r <= res_nxt;
    end
  end

  // Drive the result channel
  assign out_chan.valid      = out_valid_r;
  assign out_chan.echo_valid = res_r.echo_valid;
  assign out_chan.echo_byte  = res_r.echo_byte;
  assign out_chan.line_done  = res_r.line_done;
  assign out_chan.cmd_text   = res_r.cmd_text;
  assign out_chan.cmd_len    = res_r.cmd_len;
  assign out_chan.arg_text   = res_r.arg_text;
  assign out_chan.arg_len    = res_r.arg_len;
  assign out_chan.val_text   = res_r.val_text;
  assign out_chan.val_len    = res_r.val_len;

`ifndef SYNTHESIS
  // The shared pointer never runs past the widest field
  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r <= clt_pkg::ptr_t'(clt_pkg::MAX_CHARS))
    else $error("write pointer beyond field capacity");

  // Stored lengths stay within each field's capacity
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (clt_pkg::ptr_t'(cmd_length_r) <= clt_pkg::ptr_t'(clt_pkg::CMD_CHARS)) &&
    (clt_pkg::ptr_t'(arg_length_r) <= clt_pkg::ptr_t'(clt_pkg::ARG_CHARS)) &&
    (clt_pkg::ptr_t'(val_length_r) <= clt_pkg::ptr_t'(clt_pkg::VAL_CHARS)))
    else $error("field length beyond capacity");

  // A result without a finished line carries no text or lengths
  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.line_done) |->
    (res_r.cmd_text == '0 && res_r.arg_text == '0 && res_r.val_text == '0 &&
     res_r.cmd_len == '0 && res_r.arg_len == '0 && res_r.val_len == '0))
    else $error("text fields set without a finished line");

  // A finished line leaves the state ready for a fresh command
  a_line_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_adv && s0_byte_r == clt_pkg::CH_LF) |=>
    (part_r == clt_pkg::PART_CMD && wp_r == '0 && cmd_length_r == '0))
    else $error("line state not cleared after newline");
`endif

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command line tokenizer testbench
// Feeds received bytes through the core and compares every result item,
// field by field, with a line-folding predictor kept in a scoreboard. Echo is
// switched on and off between phases while the core is idle.
// ----------------------------------------------------------------------------
module testbench;

  // Generous bound: about a thousand items with random gaps and stalls
  localparam int CYCLE_LIMIT = 200000;

  // Index of each text field in the predictor's stores
  typedef enum int {
    FLD_CMD = 0,
    FLD_ARG = 1,
    FLD_VAL = 2
  } text_field_t;

  // --------------------------------------------------------------------------
  // Scoreboard: folds each accepted byte into its own copy of the line state
  // and keeps the results that the core has still to deliver.
  // --------------------------------------------------------------------------
  class line_scoreboard;
    bit               echo_on;
    clt_pkg::part_t   part;
    int               wptr;
    clt_pkg::byte_t   text [3][clt_pkg::MAX_CHARS];
    int               lens [3];
    int               caps [3];
    clt_pkg::result_t pending_results [$];
    int               errors;

    function new();
      echo_on = 1'b0;
      part    = clt_pkg::PART_CMD;
      wptr    = 0;
      errors  = 0;
      caps    = '{clt_pkg::CMD_CHARS, clt_pkg::ARG_CHARS, clt_pkg::VAL_CHARS};
      foreach (text[f, i]) text[f][i] = '0;
      foreach (lens[f]) lens[f] = 0;
    endfunction

    function void set_echo(bit on);
      echo_on = on;
    endfunction

    function int pending_count();
      return pending_results.size();
    endfunction

    function bit is_gap_char(clt_pkg::byte_t c);
      case (c)
        clt_pkg::CH_SPACE, clt_pkg::CH_TAB, clt_pkg::CH_VT, clt_pkg::CH_FF,
        clt_pkg::CH_CR: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    // Write at the shared pointer while there is room; the length follows it
    function void store_char(text_field_t f, clt_pkg::byte_t c);
      if (wptr < caps[f] && wptr < clt_pkg::MAX_CHARS) begin
        text[f][wptr] = c;
        wptr++;
        lens[f] = wptr;
      end
    endfunction

    function logic [63:0] packed_text(text_field_t f);
      logic [63:0] v;
      v = '0;
      for (int i = 0; i < lens[f] && i < clt_pkg::MAX_CHARS; i++) v[8*i +: 8] = text[f][i];
      return v;
    endfunction

    function int saturated(int n, int top);
      return (n > top) ? top : n;
    endfunction

    function void clear_line();
      foreach (lens[f]) lens[f] = 0;
      wptr = 0;
      part = clt_pkg::PART_CMD;
    endfunction

    function void note_rx_byte(clt_pkg::byte_t c);
      clt_pkg::result_t r;
      r = '0;
      if (c == clt_pkg::CH_NUL) begin
        pending_results.push_back(r);
        return;
      end
      // Ctrl-U echoes a carriage return whatever the echo setting
      if (c == clt_pkg::CH_CTRL_U) begin
        clear_line();
        r.echo_valid = 1'b1;
        r.echo_byte  = clt_pkg::CH_CR;
        pending_results.push_back(r);
        return;
      end
      if (echo_on) begin
        r.echo_valid = 1'b1;
        r.echo_byte  = c;
      end
      if (c == clt_pkg::CH_BS) begin
        if (wptr > 0) wptr--;
        pending_results.push_back(r);
        return;
      end
      if (c == clt_pkg::CH_LF) begin
        r.line_done = 1'b1;
        r.cmd_text  = clt_pkg::CMD_TEXT_W'(packed_text(FLD_CMD));
        r.cmd_len   = clt_pkg::CMD_LEN_OUT_W'(saturated(lens[FLD_CMD], 7));
        r.arg_text  = packed_text(FLD_ARG);
        r.arg_len   = clt_pkg::ARG_LEN_OUT_W'(saturated(lens[FLD_ARG], 15));
        r.val_text  = packed_text(FLD_VAL);
        r.val_len   = clt_pkg::VAL_LEN_OUT_W'(saturated(lens[FLD_VAL], 15));
        clear_line();
        pending_results.push_back(r);
        return;
      end
      if (c == clt_pkg::CH_HASH) part = clt_pkg::PART_NOTE;
      case (part)
        clt_pkg::PART_CMD: begin
          if (is_gap_char(c)) part = clt_pkg::PART_GAP1;
          else store_char(FLD_CMD, c);
        end
        clt_pkg::PART_GAP1: begin
          if (!is_gap_char(c)) begin
            text[FLD_ARG][0] = c;
            lens[FLD_ARG] = 1;
            wptr = 1;
            part = clt_pkg::PART_ARG;
          end
        end
        clt_pkg::PART_ARG: begin
          if (is_gap_char(c)) part = clt_pkg::PART_GAP2;
          else store_char(FLD_ARG, c);
        end
        clt_pkg::PART_GAP2: begin
          if (!is_gap_char(c)) begin
            text[FLD_VAL][0] = c;
            lens[FLD_VAL] = 1;
            wptr = 1;
            part = clt_pkg::PART_VAL;
          end
        end
        clt_pkg::PART_VAL: store_char(FLD_VAL, c);
        default: ;
      endcase
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] seen);
      if (want !== seen) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, seen);
      end
    endfunction

    function void check_line_result(clt_pkg::result_t got);
      clt_pkg::result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result item with nothing expected, actual %h", $time, got);
        return;
      end
      want = pending_results.pop_front();
      compare_field("echo_valid", 64'(want.echo_valid), 64'(got.echo_valid));
      compare_field("echo_byte",  64'(want.echo_byte),  64'(got.echo_byte));
      compare_field("line_done",  64'(want.line_done),  64'(got.line_done));
      compare_field("cmd_text",   64'(want.cmd_text),   64'(got.cmd_text));
      compare_field("cmd_len",    64'(want.cmd_len),    64'(got.cmd_len));
      compare_field("arg_text",   64'(want.arg_text),   64'(got.arg_text));
      compare_field("arg_len",    64'(want.arg_len),    64'(got.arg_len));
      compare_field("val_text",   64'(want.val_text),   64'(got.val_text));
      compare_field("val_len",    64'(want.val_len),    64'(got.val_len));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and channels
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;

  always #5 clk = ~clk;

  clt_in_if  in_chan ();
  clt_out_if out_chan ();
  clt_cfg_if cfg_chan ();

  command_line_tokenizer_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  line_scoreboard sb = new();

  int               cycles   = 0;
  int               rx_count = 0;   // non-zero bytes accepted for driving, ignored bytes excluded
  bit               steady   = 1'b0; // high: neither side idles
  clt_pkg::result_t seen_result;

  // Watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, sb.pending_count());
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: stall about a quarter of the cycles, never while steady
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else if (steady) begin
      out_chan.ready <= 1'b1;
    end else begin
      out_chan.ready <= ($urandom_range(0, 99) >= 25);
    end
  end

  // Monitors: all sample the values from before the edge, so order is moot
  always @(posedge clk) begin
    if (rst_n && in_chan.valid && in_chan.ready) sb.note_rx_byte(in_chan.rx_byte);
  end

  always @(posedge clk) begin
    if (rst_n && cfg_chan.valid && cfg_chan.ready) sb.set_echo(cfg_chan.echo_enable);
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      seen_result.echo_valid = out_chan.echo_valid;
      seen_result.echo_byte  = out_chan.echo_byte;
      seen_result.line_done  = out_chan.line_done;
      seen_result.cmd_text   = out_chan.cmd_text;
      seen_result.cmd_len    = out_chan.cmd_len;
      seen_result.arg_text   = out_chan.arg_text;
      seen_result.arg_len    = out_chan.arg_len;
      seen_result.val_text   = out_chan.val_text;
      seen_result.val_len    = out_chan.val_len;
      sb.check_line_result(seen_result);
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offer one byte and hold it until accepted. Valid stays high after the
  // handshake so back-to-back items never lower and raise it in one step;
  // drop it only when idling.
  task automatic send_byte(input clt_pkg::byte_t b);
    if (!steady && $urandom_range(0, 99) < 25) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.rx_byte <= b;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    if (b != clt_pkg::CH_NUL) rx_count++;
  endtask

  // Hold the sender back until every expected result has come out; the extra
  // edge lets the monitor note the last accepted byte first
  task automatic wait_for_results();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_count() != 0) @(posedge clk);
  endtask

  // Write echo_enable; only called while the core is idle
  task automatic write_echo(input bit on);
    cfg_chan.valid       <= 1'b1;
    cfg_chan.echo_enable <= on;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  // A character inside a word: mostly printable, some high bytes, now and
  // then a backspace, an empty byte or a line clear
  function automatic clt_pkg::byte_t word_char();
    int r;
    clt_pkg::byte_t c;
    r = $urandom_range(0, 99);
    if (r < 4) return clt_pkg::CH_BS;
    if (r < 6) return clt_pkg::CH_NUL;
    if (r < 7) return clt_pkg::CH_CTRL_U;
    if (r < 27) return clt_pkg::byte_t'($urandom_range(128, 255));
    c = clt_pkg::byte_t'($urandom_range(33, 126));
    return (c == clt_pkg::CH_HASH) ? clt_pkg::byte_t'("A") : c;
  endfunction

  function automatic clt_pkg::byte_t gap_char();
    clt_pkg::byte_t gaps [5];
    gaps = '{clt_pkg::CH_SPACE, clt_pkg::CH_TAB, clt_pkg::CH_VT, clt_pkg::CH_FF,
             clt_pkg::CH_CR};
    return gaps[$urandom_range(0, 4)];
  endfunction

  task automatic send_word(input int n);
    repeat (n) send_byte(word_char());
  endtask

  task automatic send_gap();
    repeat ($urandom_range(1, 2)) send_byte(gap_char());
  endtask

  // Mostly well-formed lines with random content and overflowing words;
  // the rest is raw noise that may or may not end in a newline
  task automatic send_line();
    int n;
    if ($urandom_range(0, 99) < 12) begin
      n = $urandom_range(1, 12);
      repeat (n) send_byte(clt_pkg::byte_t'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) == 1) send_byte(clt_pkg::CH_LF);
      return;
    end
    send_word($urandom_range(0, 6));
    send_gap();
    send_word($urandom_range(0, 10));
    send_gap();
    n = $urandom_range(0, 10);
    repeat (n) send_byte(($urandom_range(0, 4) == 0) ? clt_pkg::CH_SPACE : word_char());
    if ($urandom_range(0, 9) == 0) begin
      send_byte(clt_pkg::CH_HASH);
      repeat ($urandom_range(0, 3)) send_byte(clt_pkg::byte_t'($urandom_range(1, 255)));
    end
    send_byte(clt_pkg::CH_LF);
  endtask

  task automatic send_lines_until(input int target);
    while (rx_count < target) send_line();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    clt_pkg::byte_t directed [$];

    rst_n                = 1'b0;
    in_chan.valid        = 1'b0;
    in_chan.rx_byte      = '0;
    cfg_chan.valid       = 1'b0;
    cfg_chan.echo_enable = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed line with echo on: an empty byte, a backspace, an overfull
    // command, high bytes in the argument, every blank, spaces in the value,
    // a comment, the newline report and a line clear
    write_echo(1'b1);
    directed = '{clt_pkg::CH_NUL, "r", "w", clt_pkg::CH_BS, "x", "y", "z", "q",
                 clt_pkg::CH_TAB, 8'hFF, 8'h80, clt_pkg::CH_CR, clt_pkg::CH_VT,
                 clt_pkg::CH_FF, "a", clt_pkg::CH_SPACE, "b", clt_pkg::CH_HASH, "c",
                 clt_pkg::CH_LF, clt_pkg::CH_CTRL_U, "#", "k", clt_pkg::CH_LF};
    foreach (directed[i]) send_byte(directed[i]);
    wait_for_results();

    // Random lines, echo off
    write_echo(1'b0);
    send_lines_until(rx_count + 350);
    wait_for_results();

    // Echo on, first a stretch where neither side idles
    write_echo(1'b1);
    steady = 1'b1;
    send_lines_until(rx_count + 200);
    steady = 1'b0;
    send_lines_until(rx_count + 250);
    wait_for_results();

    // Echo off again to finish
    write_echo(1'b0);
    send_lines_until(rx_count + 200);
    wait_for_results();

    // Run on after the last result so stray results are caught
    repeat (6) @(posedge clk);
    if (sb.errors == 0 && sb.pending_count() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* files.f */
sv/clt_pkg.sv
sv/clt_if.sv
sv/command_line_tokenizer_core.sv
tb/sv/testbench.sv
